### rtl/rgbpk_pkg.sv
package rgbpk_pkg;

  // largest frame dimension accepted on either axis
  localparam int unsigned MAX_DIM = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FORMAT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FORMAT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FORMAT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd7;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [23:0] color;
  } in_word_t;

  typedef struct packed {
    logic [27:0] byte_offset;
    logic [31:0] pixel_value;
    logic [2:0]  byte_count;
  } out_word_t;

  // channel format: width in bits 3:0 capped at eight, shift in bits 8:4
  function automatic logic [7:0] chan_top(input logic [8:0] fmt);
    logic [3:0] n;
    logic [8:0] t;
    n = (fmt[3:0] > 4'd8) ? 4'd8 : fmt[3:0];
    t = (9'd1 << n) - 9'd1;
    return t[7:0];
  endfunction

  // floor(p / 255), exact for p below 65280
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

### rtl/rgb_pixel_pack_and_address_unit.sv
// Pixel packer and address generator. One word may be started in every clock
// cycle (busy is held low) and its result appears on out_data with out_strobe
// after the three register stages of the pipeline: channel and row
// multipliers, divide-by-255 and offset add, then shift-and-merge into the
// packed word. The receiver cannot stall, so each result is shown for one
// cycle only. Words outside the frame or started while disabled give no
// strobe. Configuration writes take effect at once and are meant for when no
// word is in flight.
module rgb_pixel_pack_and_address_unit
  import rgbpk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  output logic                  out_strobe,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [16:0] MaxDim = 17'(MAX_DIM);

  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [15:0] row_stride_r;
  logic [2:0]  pixel_bytes_r;
  logic [8:0]  red_format_r;
  logic [8:0]  green_format_r;
  logic [8:0]  blue_format_r;
  logic        enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      row_stride_r   <= 16'd2560;
      pixel_bytes_r  <= 3'd4;
      red_format_r   <= 9'd264;
      green_format_r <= 9'd136;
      blue_format_r  <= 9'd8;
      enable_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[12:0];
        REG_ROW_STRIDE:   row_stride_r   <= cfg_data;
        REG_PIXEL_BYTES:  pixel_bytes_r  <= cfg_data[2:0];
        REG_RED_FORMAT:   red_format_r   <= cfg_data[8:0];
        REG_GREEN_FORMAT: green_format_r <= cfg_data[8:0];
        REG_BLUE_FORMAT:  blue_format_r  <= cfg_data[8:0];
        REG_ENABLE:       enable_r       <= cfg_data[0];
        default:          enable_r       <= enable_r;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [16:0] lim_x;
  logic [16:0] lim_y;
  logic        in_frame;
  logic        is_24bpp;
  logic [2:0]  bpp;

  assign lim_x    = ({4'd0, frame_width_r} > MaxDim) ? MaxDim : {4'd0, frame_width_r};
  assign lim_y    = ({4'd0, frame_height_r} > MaxDim) ? MaxDim : {4'd0, frame_height_r};
  assign in_frame = ({5'd0, in_data.pos_x} < lim_x) && ({5'd0, in_data.pos_y} < lim_y);
  assign is_24bpp = (pixel_bytes_r == 3'd3);
  assign bpp      = is_24bpp ? 3'd3 : 3'd4;

  // stage a: products
  logic        va_r;
  logic [15:0] prod_r_r, prod_g_r, prod_b_r;
  logic [27:0] row_off_r;
  logic [13:0] col_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start && enable_r && in_frame;
    end
  end

  always_ff @(posedge clk) begin
    prod_r_r  <= {8'd0, in_data.color[23:16]} * {8'd0, chan_top(red_format_r)};
    prod_g_r  <= {8'd0, in_data.color[15:8]} * {8'd0, chan_top(green_format_r)};
    prod_b_r  <= {8'd0, in_data.color[7:0]} * {8'd0, chan_top(blue_format_r)};
    row_off_r <= {16'd0, in_data.pos_y} * {12'd0, row_stride_r};
    col_off_r <= is_24bpp ? ({2'd0, in_data.pos_x} + {1'd0, in_data.pos_x, 1'b0})
                          : {in_data.pos_x, 2'b00};
  end

  // stage b: rounding divide by 255 and offset sum
  logic        vb_r;
  logic [7:0]  lvl_r_r, lvl_g_r, lvl_b_r;
  logic [27:0] offset_r;
  logic [28:0] offset_sum;

  assign offset_sum = {1'b0, row_off_r} + {15'd0, col_off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r_r  <= div255(prod_r_r + 16'd127);
    lvl_g_r  <= div255(prod_g_r + 16'd127);
    lvl_b_r  <= div255(prod_b_r + 16'd127);
    offset_r <= offset_sum[27:0];
  end

  // stage c: place channels and merge; bits above 31 fall off
  logic [31:0] word_nxt;

  assign word_nxt = ({24'd0, lvl_r_r} << red_format_r[8:4])
                  | ({24'd0, lvl_g_r} << green_format_r[8:4])
                  | ({24'd0, lvl_b_r} << blue_format_r[8:4]);

  logic      strobe_r;
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.byte_offset <= offset_r;
    out_r.pixel_value <= word_nxt;
    out_r.byte_count  <= bpp;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start, 3) && $past(enable_r, 3)))
    else $error("result strobe without an enabled start three cycles earlier");

  a_strobe_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({5'd0, $past(in_data.pos_x, 3)} < lim_x &&
                    {5'd0, $past(in_data.pos_y, 3)} < lim_y))
    else $error("result given for a position outside the frame");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.byte_count == 3'd3 || out_data.byte_count == 3'd4))
    else $error("byte count is neither three nor four");

endmodule
